@@ design/b64d_pkg.sv @@
// shared types and constants for the base64 stream decoder
`default_nettype none

package b64d_pkg;

  typedef enum logic [1:0] {
    MODE_RUNNING = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_FAILED  = 2'd2
  } mode_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef enum logic [1:0] {
    CLS_DATA  = 2'd0,
    CLS_BLANK = 2'd1,
    CLS_PAD   = 2'd2,
    CLS_BAD   = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [5:0] sextet;
    logic       last;
  } entry_t;

  typedef enum logic {
    PH_FIRST = 1'b0,
    PH_END   = 1'b1
  } phase_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       pop;
    logic       update;
    logic       clear;
  } action_t;

endpackage

`default_nettype wire

@@ design/b64d_front.sv @@
// front end: takes characters and classifies them into queue entries
`default_nettype none

module b64d_front (
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,
  input  wire logic            s_tlast,
  input  wire logic            q_full,
  output logic                 push,
  output b64d_pkg::entry_t     entry
);
  import b64d_pkg::*;

  always_comb begin
    entry.last   = s_tlast;
    entry.sextet = 6'd0;
    entry.cls    = CLS_BAD;
    if (s_tdata >= 8'h41 && s_tdata <= 8'h5A) begin
      entry.cls    = CLS_DATA;
      entry.sextet = 6'(s_tdata - 8'h41);
    end else if (s_tdata >= 8'h61 && s_tdata <= 8'h7A) begin
      entry.cls    = CLS_DATA;
      entry.sextet = 6'(s_tdata - 8'h61 + 8'd26);
    end else if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
      entry.cls    = CLS_DATA;
      entry.sextet = 6'(s_tdata - 8'h30 + 8'd52);
    end else if (s_tdata == 8'h2B) begin
      entry.cls    = CLS_DATA;
      entry.sextet = 6'd62;
    end else if (s_tdata == 8'h2F) begin
      entry.cls    = CLS_DATA;
      entry.sextet = 6'd63;
    end else if (s_tdata == 8'h3D) begin
      entry.cls = CLS_PAD;
    end else if (s_tdata == 8'h20 || (s_tdata >= 8'h09 && s_tdata <= 8'h0D)) begin
      entry.cls = CLS_BLANK;
    end
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

endmodule

`default_nettype wire

@@ design/b64d_queue.sv @@
// two-entry queue between front and back
`default_nettype none

module b64d_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64d_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output b64d_pkg::entry_t      head
);
  import b64d_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count[1];
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/b64d_back.sv @@
// back end: decode state, byte assembly and result register
`default_nettype none

module b64d_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire b64d_pkg::entry_t head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);
  import b64d_pkg::*;

  mode_t      mode;
  logic [5:0] residue;
  logic [1:0] pairs;
  phase_t     phase;
  phase_t     phase_next;

  mode_t      mode_next;
  logic [5:0] residue_next;
  logic [1:0] pairs_next;
  logic [7:0] step_byte;
  logic       data_ok;
  logic       has_byte;
  logic       out_free;
  logic       go;
  action_t    act;

  // residue assembly
  always_comb begin
    step_byte    = 8'd0;
    residue_next = 6'd0;
    pairs_next   = 2'd0;
    case (pairs)
      2'd0: begin
        residue_next = head.sextet;
        pairs_next   = 2'd3;
      end
      2'd1: begin
        step_byte  = {residue[1:0], head.sextet};
        pairs_next = 2'd0;
      end
      2'd2: begin
        step_byte    = {residue[3:0], head.sextet[5:2]};
        residue_next = {4'd0, head.sextet[1:0]};
        pairs_next   = 2'd1;
      end
      2'd3: begin
        step_byte    = {residue[5:0], head.sextet[5:4]};
        residue_next = {2'd0, head.sextet[3:0]};
        pairs_next   = 2'd2;
      end
      default: begin
        step_byte    = 8'd0;
        residue_next = 6'd0;
        pairs_next   = 2'd0;
      end
    endcase
  end

  always_comb begin
    mode_next = mode;
    if (mode == MODE_RUNNING) begin
      case (head.cls)
        CLS_PAD: mode_next = MODE_STOPPED;
        CLS_BAD: mode_next = MODE_FAILED;
        default: mode_next = MODE_RUNNING;
      endcase
    end
  end

  assign data_ok  = (head.cls == CLS_DATA) && (mode == MODE_RUNNING);
  assign has_byte = data_ok && (pairs != 2'd0);

  // actions for the head request
  always_comb begin
    act = '0;
    case (phase)
      PH_END: begin
        act.emit  = 1'b1;
        act.kind  = KIND_OK;
        act.last  = 1'b1;
        act.pop   = 1'b1;
        act.clear = 1'b1;
      end
      PH_FIRST: begin
        if (has_byte) begin
          act.emit   = 1'b1;
          act.kind   = KIND_BYTE;
          act.data   = step_byte;
          act.last   = !head.last;
          act.pop    = !head.last;
          act.update = !head.last;
        end else if (head.last) begin
          act.emit  = 1'b1;
          act.kind  = (mode_next == MODE_RUNNING || mode_next == MODE_STOPPED) ?
                      KIND_OK : KIND_BAD;
          act.last  = 1'b1;
          act.pop   = 1'b1;
          act.clear = 1'b1;
        end else begin
          act.pop    = 1'b1;
          act.update = 1'b1;
        end
      end
      default: act = '0;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign go       = head_valid && (!act.emit || out_free);
  assign pop      = go && act.pop;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_FIRST: if (go && has_byte && head.last) phase_next = PH_END;
      PH_END:   if (go) phase_next = PH_FIRST;
      default:  phase_next = PH_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FIRST;
      mode    <= MODE_RUNNING;
      residue <= 6'd0;
      pairs   <= 2'd0;
    end else begin
      phase <= phase_next;
      if (go && act.clear) begin
        mode    <= MODE_RUNNING;
        residue <= 6'd0;
        pairs   <= 2'd0;
      end else if (go && act.update) begin
        mode <= mode_next;
        if (data_ok) begin
          residue <= residue_next;
          pairs   <= pairs_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && act.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && act.emit) begin
      m_tdata <= act.data;
      m_tuser <= act.kind;
      m_tlast <= act.last;
    end
  end

endmodule

`default_nettype wire

@@ design/base64_stream_decoder.sv @@
// top level of the base64 stream decoder
//
// channel  dir  tdata              tuser     tlast
// s_*      in   [7:0] char_code    -         end_of_text
// m_*      out  [7:0] byte_out     [1:0] kind run_last
//
// one character request per cycle while the queue has room; a character that
// yields a byte and ends the text gives two results, limited by the single output
// register; the front classifies in the accept cycle, the back decodes one queue
// entry per cycle if the output is free; results are registered off the queue head
// reset is synchronous and clears queue, decode state and output valid
// a stalled output fills the two-entry queue before s_tready drops
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_code
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] byte_out
  output logic [1:0]      m_tuser,   // [1:0] kind
  output logic            m_tlast
);
  import b64d_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   q_full;
  logic   head_valid;
  logic   pop;

  b64d_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

@@ design/b64d_checker.sv @@
// port-level checks for the base64 stream decoder
`default_nettype none

module b64d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [1:0] m_tuser,
  input wire logic       m_tlast
);
  import b64d_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BYTE |-> m_tlast)
    else $error("end result without last flag");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BYTE |-> m_tdata == 8'd0)
    else $error("end result with nonzero data");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == KIND_BYTE || m_tuser == KIND_OK || m_tuser == KIND_BAD)
    else $error("unknown result kind");

  a_idle_tail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == KIND_BYTE && !m_tlast |=> m_tvalid)
    else $error("byte of final character not followed by end result");

endmodule

bind base64_stream_decoder b64d_checker u_chk (.*);

`default_nettype wire

@@ tb/base64_stream_decoder_test.sv @@
// self-checking testbench for the base64 stream decoder: directed and random text
`default_nettype none

module base64_stream_decoder_test;
  import b64d_pkg::*;

  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int RANDOM_CHARS = 610;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [7:0] code;
    logic       eot;
    bit         hold;
  } text_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] char_code
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] byte_out
  logic [1:0] m_tuser;          // [1:0] kind
  logic       m_tlast;

  text_item_t  text_q[$];
  dec_result_t owed_results[$];

  // predictor state
  logic [5:0] residue;
  logic [2:0] held_bits;
  mode_t      dec_mode;

  int total_chars;
  int chars_sent;
  int strings_made;
  int results_checked;
  int bytes_checked;
  int errors;
  int tx_idle;
  int rx_idle;
  int stall_cycles;

  base64_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int char_sextet(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic eot);
    int          v;
    logic [11:0] acc;
    int          total;
    bit          have_byte;
    dec_result_t r;
    have_byte = 1'b0;
    r.kind = KIND_BYTE;
    r.data = 8'h00;
    r.last = 1'b0;
    if (dec_mode == MODE_RUNNING) begin
      if (c == PAD_CHAR) begin
        dec_mode = MODE_STOPPED;
      end else if (!is_blank(c)) begin
        v = char_sextet(c);
        if (v < 0) begin
          dec_mode = MODE_FAILED;
        end else begin
          acc = {residue, 6'(v)};
          acc = acc & ((12'd1 << (held_bits + 6)) - 12'd1);
          total = held_bits + 6;
          if (total >= 8) begin
            total -= 8;
            have_byte = 1'b1;
            r.data = 8'(acc >> total);
          end
          held_bits = 3'(total);
          residue = 6'(acc & ((12'd1 << total) - 12'd1));
        end
      end
    end
    if (have_byte) begin
      r.last = !eot;
      owed_results = {owed_results, r};
    end
    if (eot) begin
      r.kind = (dec_mode == MODE_RUNNING || dec_mode == MODE_STOPPED) ? KIND_OK : KIND_BAD;
      r.data = 8'h00;
      r.last = 1'b1;
      owed_results = {owed_results, r};
      residue = '0;
      held_bits = '0;
      dec_mode = MODE_RUNNING;
    end
  endtask

  task automatic add_char(input logic [7:0] c, input logic eot, input bit hold);
    text_item_t t;
    t.code = c;
    t.eot = eot;
    t.hold = hold;
    text_q = {text_q, t};
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(9, 14);
    return (k == 14) ? 8'h20 : 8'(k);
  endfunction

  function automatic logic [7:0] invalid_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (char_sextet(c) >= 0 || is_blank(c) || c == PAD_CHAR);
    return c;
  endfunction

  task automatic add_random_string(input bit hold);
    logic [7:0] codes[$];
    int         shape;
    int         len;
    int         npad;
    int         i;
    shape = $urandom_range(99);
    if (shape < 15) begin
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++) codes = {codes, 8'($urandom_range(255))};
    end else begin
      len = $urandom_range(1, 16);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) codes = {codes, blank_char()};
        codes = {codes, ALPHABET[$urandom_range(63)]};
      end
      npad = $urandom_range(2);
      for (i = 0; i < npad; i++) codes = {codes, PAD_CHAR};
      if (npad > 0 && $urandom_range(3) == 0) begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) codes = {codes, 8'($urandom_range(255))};
      end
      // broken text: a malformed byte somewhere inside
      if (shape < 35) codes[$urandom_range(codes.size() - 1)] = invalid_char();
      if ($urandom_range(7) == 0) codes = {codes, blank_char()};
    end
    for (i = 0; i < codes.size(); i++)
      add_char(codes[i], i == codes.size() - 1, hold && i == 0);
    strings_made++;
  endtask

  // request driver
  always @(posedge clk) begin
    bit next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_char(text_q[0].code, text_q[0].eot);
        void'(text_q.pop_front());
        chars_sent++;
        case (chars_sent * 3 / total_chars)
          0: begin
            tx_idle = 14;
            rx_idle = 62;
          end
          1: begin
            tx_idle = 62;
            rx_idle = 14;
          end
          default: begin
            tx_idle = 0;
            rx_idle = 0;
          end
        endcase
      end
      if (s_tvalid && !s_tready)
        next_valid = 1'b1;
      else
        next_valid = text_q.size() != 0 && !(text_q[0].hold && owed_results.size() != 0)
                     && $urandom_range(99) >= tx_idle;
      s_tvalid <= next_valid;
      if (next_valid) begin
        s_tdata <= text_q[0].code;
        s_tlast <= text_q[0].eot;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    dec_result_t r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: kind %0d byte_out %02h run_last %0b",
                 m_tuser, m_tdata, m_tlast);
          errors++;
        end else begin
          r = owed_results.pop_front();
          if (m_tuser !== r.kind) begin
            $error("kind: expected %0d, got %0d", r.kind, m_tuser);
            errors++;
          end
          if (m_tdata !== r.data) begin
            $error("byte_out: expected %02h, got %02h", r.data, m_tdata);
            errors++;
          end
          if (m_tlast !== r.last) begin
            $error("run_last: expected %0b, got %0b", r.last, m_tlast);
            errors++;
          end
          results_checked++;
          if (r.kind == KIND_BYTE) bytes_checked++;
        end
      end
      m_tready <= $urandom_range(99) >= rx_idle;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results still owed",
                 stall_cycles, owed_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    residue = '0;
    held_bits = '0;
    dec_mode = MODE_RUNNING;
    chars_sent = 0;
    strings_made = 0;
    results_checked = 0;
    bytes_checked = 0;
    errors = 0;
    tx_idle = 14;
    rx_idle = 62;
    stall_cycles = 0;

    // "Man", last character yields a byte and the end result
    add_char("T", 1'b0, 1'b0);
    add_char("W", 1'b0, 1'b0);
    add_char("F", 1'b0, 1'b0);
    add_char("u", 1'b1, 1'b0);
    // alphabet extremes with a skipped space and leftover bits
    add_char("/", 1'b0, 1'b0);
    add_char("+", 1'b0, 1'b0);
    add_char("z", 1'b0, 1'b0);
    add_char("9", 1'b0, 1'b0);
    add_char(8'h20, 1'b0, 1'b0);
    add_char("A", 1'b0, 1'b0);
    add_char("Z", 1'b0, 1'b0);
    add_char("0", 1'b1, 1'b0);
    // padding stops decoding, later bytes ignored
    add_char(8'h09, 1'b0, 1'b0);
    add_char(8'h0D, 1'b0, 1'b0);
    add_char("a", 1'b0, 1'b0);
    add_char(PAD_CHAR, 1'b0, 1'b0);
    add_char(8'hFF, 1'b0, 1'b0);
    add_char("A", 1'b1, 1'b0);
    // malformed byte first, then ignored characters
    add_char(8'h00, 1'b0, 1'b0);
    add_char("A", 1'b0, 1'b0);
    add_char(8'h20, 1'b1, 1'b0);
    // byte already out, end on a malformed byte
    add_char("Q", 1'b0, 1'b0);
    add_char("U", 1'b0, 1'b0);
    add_char(8'hFF, 1'b1, 1'b0);
    // one-character strings ending on padding and on whitespace
    add_char(PAD_CHAR, 1'b1, 1'b0);
    add_char(8'h0A, 1'b1, 1'b0);
    strings_made = 7;

    while (text_q.size() < 26 + RANDOM_CHARS)
      add_random_string(strings_made % 40 == 8);
    total_chars = text_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0 || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters in %0d strings sent, %0d results checked (%0d data bytes)",
             chars_sent, strings_made, results_checked, bytes_checked);
    $display("idling phases: sender-light, receiver-light, none; %0d mismatches", errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
